### hdl/bdeq_pkg.sv
// Package for the bounded double-ended queue.
// Holds item types, opcode and status codes, and default sizes.
// No dependencies.
package bdeq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int WORD_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] read_value;
  } out_item_t;

  // Registered result control handed from the controller to the output mux.
  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic              use_ram;
    logic [WORD_W-1:0] fixed_value;
  } res_ctl_t;

endpackage

### hdl/bounded_double_ended_queue.sv
// Bounded double-ended queue, top level.
// Result strobe comes the cycle after an item is taken; one item per cycle outside reset.
// The entry RAM read port (registered read) gives a peeked word alongside its result strobe.
// Sync reset: front and count to 0, rear to last entry, capacity to 16; busy is high in reset.
// Entry contents are not cleared; only written entries are ever read. The receiver cannot stall.
// Depends on bdeq_pkg, bdeq_ctrl, bdeq_ram.
module bounded_double_ended_queue #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  bdeq_pkg::in_item_t         item,
  // result channel: one strobe cycle per item
  output logic                       done,
  output bdeq_pkg::out_item_t        result,
  // capacity register write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bdeq_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW = $clog2(DEPTH);

  logic                        accept;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [bdeq_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  bdeq_pkg::res_ctl_t          res_ctl;

  // Hold off commands only while in reset; every other cycle takes an item.
  assign busy      = rst;
  assign accept    = start & ~busy;
  // The capacity register takes a write in any cycle outside reset.
  assign cfg_ready = ~rst;

  // Index/count bookkeeping and RAM request generation.
  bdeq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .res_ctl  (res_ctl)
  );

  // Entry store. A push writes at the accept edge and a peek in the next
  // cycle reads at the following edge, so no forwarding is needed.
  bdeq_ram #(
    .WIDTH(bdeq_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Present the result: the peeked word straight from the RAM read register,
  // otherwise the registered fixed value (-1 for an empty peek, else 0).
  assign done              = res_ctl.valid;
  assign result.status     = res_ctl.status;
  assign result.read_value = res_ctl.use_ram ? ram_rdata : res_ctl.fixed_value;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("item without result");

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without item");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == bdeq_pkg::ST_FULL) |-> (result.read_value == '0))
    else $error("refused push returned data");

  a_ram_only_done: assert property (@(posedge clk) disable iff (rst)
    (done && res_ctl.use_ram) |-> (result.status == bdeq_pkg::ST_DONE))
    else $error("RAM read on refused item");

endmodule

### hdl/bdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bdeq_ctrl.sv
// Queue controller: capacity register, front/rear indices, count,
// RAM access generation and the registered result control.
// Depends on bdeq_pkg.
module bdeq_ctrl #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  bdeq_pkg::in_item_t              item,
  input  logic                            cfg_we,
  input  logic [bdeq_pkg::CAP_W-1:0]      cfg_data,
  output logic                            ram_we,
  output logic [$clog2(DEPTH)-1:0]        ram_waddr,
  output logic [bdeq_pkg::WORD_W-1:0]     ram_wdata,
  output logic [$clog2(DEPTH)-1:0]        ram_raddr,
  output bdeq_pkg::res_ctl_t              res_ctl
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic [bdeq_pkg::CAP_W-1:0] capacity;
  logic [IW-1:0] front, front_next, rear, rear_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] front_up, front_dn, rear_up, rear_dn;
  logic [LW-1:0] cap_l, limit, count_l;
  logic          full, empty;
  bdeq_pkg::res_ctl_t res_next;

  assign front_up = (front == LAST) ? '0 : front + IW'(1);
  assign front_dn = (front == '0) ? LAST : front - IW'(1);
  assign rear_up  = (rear == LAST) ? '0 : rear + IW'(1);
  assign rear_dn  = (rear == '0) ? LAST : rear - IW'(1);

  assign cap_l   = LW'(capacity);
  assign limit   = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
  assign count_l = LW'(count);
  assign full    = (count_l >= limit);
  assign empty   = (count == '0);

  assign ram_wdata = item.value;
  assign ram_raddr = (item.opcode == bdeq_pkg::OP_PEEK_REAR) ? rear : front;

  always_comb begin
    front_next = front;
    rear_next  = rear;
    count_next = count;
    ram_we     = 1'b0;
    ram_waddr  = front_dn;
    res_next.valid       = accept;
    res_next.status      = bdeq_pkg::ST_DONE;
    res_next.use_ram     = 1'b0;
    res_next.fixed_value = '0;
    if (accept) begin
      unique case (item.opcode) inside
        bdeq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            res_next.status = bdeq_pkg::ST_FULL;
          end else begin
            front_next = front_dn;
            ram_we     = 1'b1;
            count_next = count + CW'(1);
          end
        end
        bdeq_pkg::OP_PUSH_REAR: begin
          ram_waddr = rear_up;
          if (full) begin
            res_next.status = bdeq_pkg::ST_FULL;
          end else begin
            rear_next  = rear_up;
            ram_we     = 1'b1;
            count_next = count + CW'(1);
          end
        end
        bdeq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            res_next.status = bdeq_pkg::ST_EMPTY;
          end else begin
            front_next = front_up;
            count_next = count - CW'(1);
          end
        end
        bdeq_pkg::OP_POP_REAR: begin
          if (empty) begin
            res_next.status = bdeq_pkg::ST_EMPTY;
          end else begin
            rear_next  = rear_dn;
            count_next = count - CW'(1);
          end
        end
        bdeq_pkg::OP_PEEK_FRONT, bdeq_pkg::OP_PEEK_REAR: begin
          if (empty) begin
            res_next.status      = bdeq_pkg::ST_EMPTY;
            res_next.fixed_value = '1;
          end else begin
            res_next.use_ram = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= bdeq_pkg::CAP_RESET;
      front         <= '0;
      rear          <= LAST;
      count         <= '0;
      res_ctl.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      front         <= front_next;
      rear          <= rear_next;
      count         <= count_next;
      res_ctl.valid <= res_next.valid;
    end
    res_ctl.status      <= res_next.status;
    res_ctl.use_ram     <= res_next.use_ram;
    res_ctl.fixed_value <= res_next.fixed_value;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_l <= DEPTH_L)
    else $error("count above depth");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (item.opcode == bdeq_pkg::OP_POP_FRONT ||
                         item.opcode == bdeq_pkg::OP_POP_REAR))
    |=> ($stable(front) && $stable(rear) && $stable(count)))
    else $error("empty pop moved an index");

  a_full_push_no_write: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |-> !ram_we)
    else $error("write while full");

endmodule
